### src/tvs_pkg.sv
// Package: constants, types and helpers for the trilinear vector sampler.
`timescale 1ns / 1ps
package tvs_pkg;
   localparam int DimXDefault = 32;
   localparam int DimYDefault = 32;
   localparam int DimZDefault = 32;
   localparam int StoreDepth = 32768;
   localparam int AddrW = 15;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      REG_INV_X  = 3'd0,
      REG_INV_Y  = 3'd1,
      REG_INV_Z  = 3'd2,
      REG_CORN_X = 3'd3,
      REG_CORN_Y = 3'd4,
      REG_CORN_Z = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GRID,
      ST_READ,
      ST_LERP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] vz;
   } vec_type;

   // floor((a*(256-w) + b*w) / 256)
   function automatic logic signed [15:0] lerp8(
      input logic signed [15:0] a, input logic signed [15:0] b, input logic [7:0] w);
      logic signed [25:0] s;
      begin
         s = 26'(a) * $signed({1'b0, 9'd256 - {1'b0, w}})
           + 26'(b) * $signed({1'b0, 1'b0, w});
         return s[23:8];
      end
   endfunction
endpackage

### src/tvs_if.sv
// Valid/ready channel interfaces for items, results and register writes.
`timescale 1ns / 1ps
interface tvs_req_if;
   logic valid;
   logic ready;
   logic op;
   logic [14:0] voxel_index;
   logic signed [15:0] load_vx;
   logic signed [15:0] load_vy;
   logic signed [15:0] load_vz;
   logic signed [19:0] pos_x;
   logic signed [19:0] pos_y;
   logic signed [19:0] pos_z;
   modport source (output valid, op, voxel_index, load_vx, load_vy, load_vz,
                   pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, op, voxel_index, load_vx, load_vy, load_vz,
                 pos_x, pos_y, pos_z, output ready);
endinterface

interface tvs_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] out_vx;
   logic signed [15:0] out_vy;
   logic signed [15:0] out_vz;
   modport source (output valid, out_vx, out_vy, out_vz, input ready);
   modport sink (input valid, out_vx, out_vy, out_vz, output ready);
endinterface

interface tvs_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [19:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### src/trilinear_vector_volume_sampler_top.sv
// Top level: register file, voxel memory, sequencer and shared lerp unit.
// Load: one item accepted on every idle cycle. Query: the result is valid after the grid
// passes (3 axes on the 2-stage grid unit), 8 memory reads and 7 lerp steps on a shared
// 3-lane unit; a new query is accepted only once the block is idle again after rsp takes the result.
// Synchronous active-high reset clears control and config registers; the voxel
// memory is not cleared.
`timescale 1ns / 1ps
module trilinear_vector_volume_sampler_top #(
   parameter int DIM_X = tvs_pkg::DimXDefault,
   parameter int DIM_Y = tvs_pkg::DimYDefault,
   parameter int DIM_Z = tvs_pkg::DimZDefault
) (
   input logic clock,
   input logic reset,
   tvs_req_if.sink req,
   tvs_rsp_if.source rsp,
   tvs_csr_if.sink csr
);
   import tvs_pkg::*;
   localparam int SXY = DIM_X * DIM_Y;
   localparam int LAST = DIM_X * DIM_Y * DIM_Z - 1;

   logic [15:0] inv_ff [3];
   logic signed [19:0] corn_ff [3];
   state_type state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic signed [19:0] pos_ff [3];
   logic [15:0] g_ff [3];
   logic [15:0] grid;
   logic [24:0] id_ff;
   vec_type mem [StoreDepth];
   vec_type rd_ff;
   vec_type nb_ff [8];
   vec_type out_ff;
   logic rvalid_ff;
   logic [1:0] gaxis;
   logic [24:0] nid;
   logic [2:0] ncode;
   logic [7:0] wsel;

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.out_vx = out_ff.vx;
   assign rsp.out_vy = out_ff.vy;
   assign rsp.out_vz = out_ff.vz;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            inv_ff[i] <= 16'd4096;
            corn_ff[i] <= '0;
         end
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_INV_X:  inv_ff[0] <= csr.data[15:0];
            REG_INV_Y:  inv_ff[1] <= csr.data[15:0];
            REG_INV_Z:  inv_ff[2] <= csr.data[15:0];
            REG_CORN_X: corn_ff[0] <= csr.data;
            REG_CORN_Y: corn_ff[1] <= csr.data;
            REG_CORN_Z: corn_ff[2] <= csr.data;
            default: ;
         endcase
      end
   end

   assign gaxis = (cnt_ff > 4'd2) ? 2'd2 : cnt_ff[1:0];
   tvs_grid #(.DIM_X(DIM_X), .DIM_Y(DIM_Y), .DIM_Z(DIM_Z)) u_grid (
      .clock(clock), .axis(gaxis), .pos(pos_ff[gaxis]), .corner(corn_ff[gaxis]),
      .inv(inv_ff[gaxis]), .grid_ff(grid));

   // read cycles 1..8 fetch neighbor cnt-1: bit0 +SXY (z), bit1 +DIM_X (y), bit2 +1 (x)
   assign ncode = cnt_ff[2:0] - 3'd1;

   always_comb begin
      nid = id_ff + (ncode[0] ? 25'(SXY) : 25'd0) + (ncode[1] ? 25'(DIM_X) : 25'd0)
          + (ncode[2] ? 25'd1 : 25'd0);
      if (nid > 25'(LAST)) nid = 25'(LAST);
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready && req.op == OP_LOAD)
         mem[req.voxel_index] <= '{req.load_vx, req.load_vy, req.load_vz};
      rd_ff <= mem[nid[AddrW-1:0]];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_IDLE: if (req.valid && req.op == OP_QUERY) begin
            state_in = ST_GRID; cnt_in = '0;
         end
         ST_GRID: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd4) begin state_in = ST_READ; cnt_in = '0; end
         end
         ST_READ: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd9) begin state_in = ST_LERP; cnt_in = '0; end
         end
         ST_LERP: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd6) state_in = ST_OUT;
         end
         ST_OUT: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rvalid_ff <= (state_ff == ST_READ) && (cnt_ff != 4'd0) && (cnt_ff < 4'd9);
      end
   end

   // lerp schedule: steps 0-3 along z, 4-5 along y, 6 along x
   always_comb begin
      if (cnt_ff < 4'd4) wsel = g_ff[2][7:0];
      else if (cnt_ff < 4'd6) wsel = g_ff[1][7:0];
      else wsel = g_ff[0][7:0];
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         pos_ff[0] <= req.pos_x; pos_ff[1] <= req.pos_y; pos_ff[2] <= req.pos_z;
      end
      if (state_ff == ST_GRID && cnt_ff >= 4'd2) g_ff[cnt_ff[1:0] - 2'd2] <= grid;
      if (state_ff == ST_READ && cnt_ff == 4'd0)
         id_ff <= 25'(g_ff[0][15:8]) + 25'(g_ff[1][15:8]) * 25'(DIM_X)
                + 25'(g_ff[2][15:8]) * 25'(SXY);
      if (rvalid_ff) nb_ff[cnt_ff[2:0] - 3'd2] <= rd_ff;
      if (state_ff == ST_LERP) begin
         case (cnt_ff)
            4'd0, 4'd1, 4'd2, 4'd3: begin
               nb_ff[cnt_ff[2:0]].vx <= lerp8(nb_ff[{cnt_ff[1:0], 1'b0}].vx,
                                              nb_ff[{cnt_ff[1:0], 1'b1}].vx, wsel);
               nb_ff[cnt_ff[2:0]].vy <= lerp8(nb_ff[{cnt_ff[1:0], 1'b0}].vy,
                                              nb_ff[{cnt_ff[1:0], 1'b1}].vy, wsel);
               nb_ff[cnt_ff[2:0]].vz <= lerp8(nb_ff[{cnt_ff[1:0], 1'b0}].vz,
                                              nb_ff[{cnt_ff[1:0], 1'b1}].vz, wsel);
            end
            4'd4, 4'd5: begin
               nb_ff[cnt_ff[2:0]].vx <= lerp8(nb_ff[{cnt_ff[0], 1'b0}].vx,
                                              nb_ff[{cnt_ff[0], 1'b1}].vx, wsel);
               nb_ff[cnt_ff[2:0]].vy <= lerp8(nb_ff[{cnt_ff[0], 1'b0}].vy,
                                              nb_ff[{cnt_ff[0], 1'b1}].vy, wsel);
               nb_ff[cnt_ff[2:0]].vz <= lerp8(nb_ff[{cnt_ff[0], 1'b0}].vz,
                                              nb_ff[{cnt_ff[0], 1'b1}].vz, wsel);
            end
            default: begin
               out_ff.vx <= lerp8(nb_ff[4].vx, nb_ff[5].vx, wsel);
               out_ff.vy <= lerp8(nb_ff[4].vy, nb_ff[5].vy, wsel);
               out_ff.vz <= lerp8(nb_ff[4].vz, nb_ff[5].vz, wsel);
            end
         endcase
      end
   end

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready) else $error("ready while busy");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(out_ff))
      else $error("result changed while stalled");
   a_read_window: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> state_ff == ST_READ) else $error("read outside window");
endmodule

### src/tvs_grid.sv
// Grid-coordinate unit: one axis per pass, product, truncate and clamp.
`timescale 1ns / 1ps
module tvs_grid #(
   parameter int DIM_X = tvs_pkg::DimXDefault,
   parameter int DIM_Y = tvs_pkg::DimYDefault,
   parameter int DIM_Z = tvs_pkg::DimZDefault
) (
   input  logic clock,
   input  logic [1:0] axis,
   input  logic signed [19:0] pos,
   input  logic signed [19:0] corner,
   input  logic [15:0] inv,
   output logic [15:0] grid_ff
);
   import tvs_pkg::*;
   logic signed [20:0] diff_ff;
   logic [15:0] inv_ff;
   logic [1:0] axis_ff;
   logic signed [37:0] prod;
   logic [15:0] top;
   logic [25:0] g;
   logic [15:0] grid_in;

   always_ff @(posedge clock) begin
      diff_ff <= 21'(pos) - 21'(corner);
      inv_ff  <= inv;
      axis_ff <= axis;
      grid_ff <= grid_in;
   end

   always_comb begin
      prod = 38'(diff_ff) * $signed({1'b0, inv_ff});
      case (axis_ff)
         2'd0: top = 16'((DIM_X - 1) * 256);
         2'd1: top = 16'((DIM_Y - 1) * 256);
         default: top = 16'((DIM_Z - 1) * 256);
      endcase
      g = prod[37:12];
      if (prod[37]) grid_in = '0;
      else if (g > 26'(top)) grid_in = top;
      else grid_in = g[15:0];
   end
endmodule
